### rtl/otc_pkg.sv
// ----------------------------------------------------------------------------
// otc_pkg
// shared constants and types of the overlapping pattern occurrence counter
// ----------------------------------------------------------------------------
package otc_pkg;

  localparam int MAX_PATTERN = 10;
  localparam int MAX_TEXT    = 64;

  localparam int DIGIT_W     = 4;
  localparam int LEN_REG_W   = 4;
  localparam int PAT_REG_W   = DIGIT_W * MAX_PATTERN;
  localparam int CFG_W       = PAT_REG_W;
  localparam int CFG_IDX_W   = 1;
  localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);
  localparam int PIDX_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W       = $clog2(MAX_TEXT + 1);

  localparam int IN_TDATA_W  = ((DIGIT_W + 7) / 8) * 8;
  localparam int RES_W       = 1 + 2 * CNT_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 1'd1;

  typedef logic [DIGIT_W-1:0] nib_t;

  typedef struct packed {
    logic take;
    logic last;
    logic hit;
  } tally_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] last_start;
    logic [CNT_W-1:0] match_count;
    logic             found;
  } res_t;

endpackage

### rtl/otc_cell.sv
// ----------------------------------------------------------------------------
// otc_cell
// one window stage: holds a digit and its valid flag, compares against its
// pattern nibble and passes the digit on to the next stage
// ----------------------------------------------------------------------------
module otc_cell import otc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic clear_i,
  input  nib_t digit_i,
  input  logic valid_i,
  input  nib_t pat_nib_i,
  input  logic active_i,
  output nib_t digit_o,
  output logic valid_o,
  output logic hit_o
);

  nib_t digit_q;
  logic valid_q, valid_d;

  // compare is taken on the digit entering this stage
  assign hit_o   = !active_i || (valid_i && (digit_i == pat_nib_i));
  assign valid_d = shift_i ? (valid_i && !clear_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      digit_q <= digit_i;
    end
  end

  assign digit_o = digit_q;
  assign valid_o = valid_q;

endmodule

### rtl/otc_tally.sv
// ----------------------------------------------------------------------------
// otc_tally
// digit counter, occurrence counter, latest start and the result register
// ----------------------------------------------------------------------------
module otc_tally import otc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tally_ctl_t        ctl_i,
  input  logic [PLEN_W-1:0] len_i,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output res_t              res_o
);

  logic [CNT_W-1:0] seen_q, seen_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] start_q, start_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q;
  logic             match;
  int               total;
  int               start_pos;

  always_comb begin
    total     = int'(seen_q) + 1;
    start_pos = total - int'(len_i) + 1;
    if (start_pos > MAX_TEXT) begin
      start_pos = MAX_TEXT;
    end
    match   = ctl_i.hit && (total >= int'(len_i));
    occ_d   = occ_q;
    start_d = start_q;
    if (match) begin
      start_d = CNT_W'(start_pos);
      if (int'(occ_q) < MAX_TEXT) begin
        occ_d = occ_q + CNT_W'(1);
      end
    end
    seen_d = (total > MAX_TEXT) ? CNT_W'(MAX_TEXT) : CNT_W'(total);
  end

  assign res_valid_d = (res_valid_q && !res_ready_i) || (ctl_i.take && ctl_i.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      occ_q       <= '0;
      start_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (ctl_i.take) begin
        if (ctl_i.last) begin
          seen_q  <= '0;
          occ_q   <= '0;
          start_q <= '0;
        end else begin
          seen_q  <= seen_d;
          occ_q   <= occ_d;
          start_q <= start_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take && ctl_i.last) begin
      res_q.found       <= (occ_d != '0);
      res_q.match_count <= occ_d;
      res_q.last_start  <= start_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/overlapping_pattern_occurrence_counter.sv
// ----------------------------------------------------------------------------
// overlapping_pattern_occurrence_counter
// counts overlapping occurrences of a digit pattern in a digit stream
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_axis   | in        | tdata[3:0] digit, tlast final digit of the text
//  m_axis   | out       | tdata[0] found, [7:1] match_count, [14:8] last_start
//  cfg      | in        | we/idx/wdata: 0 pattern digits, 1 pattern length
//
// one digit per cycle; the result of a text is valid the cycle after its
// final digit is taken. the window is a row of cells, each active one compares
// its digit with one pattern nibble in the cycle the digit enters it.
// a single output register holds a result; input stalls only while that
// register is full and not taken. reset clears the window and counters,
// pattern resets to 0 and length to 1.
module overlapping_pattern_occurrence_counter import otc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // digit
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // found, match_count, last_start
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  nib_t [MAX_PATTERN-1:0] pattern_q;
  logic [LEN_REG_W-1:0]   len_q;
  logic [PLEN_W-1:0]      len_eff;

  nib_t [MAX_PATTERN-1:0] win_digit;
  logic [MAX_PATTERN-1:0] win_valid;
  logic [MAX_PATTERN-1:0] cell_hit;

  logic       take;
  logic       res_valid;
  res_t       res;
  tally_ctl_t ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= LEN_REG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PATTERN: pattern_q <= cfg_wdata_i[PAT_REG_W-1:0];
        REG_LENGTH:  len_q     <= cfg_wdata_i[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(len_q) > MAX_PATTERN) begin
      len_eff = PLEN_W'(MAX_PATTERN);
    end else begin
      len_eff = PLEN_W'(len_q);
    end
  end

  assign s_axis_tready = !res_valid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    nib_t              d_in;
    logic              v_in;
    logic              active;
    logic [PIDX_W-1:0] pidx;

    if (k == 0) begin : g_head
      assign d_in = s_axis_tdata[DIGIT_W-1:0];
      assign v_in = 1'b1;
    end else begin : g_body
      assign d_in = win_digit[k-1];
      assign v_in = win_valid[k-1];
    end

    // cell k holds the digit k steps back, matched against nibble len-1-k
    assign active = (k < int'(len_eff));
    assign pidx   = PIDX_W'(int'(len_eff) - 1 - k);

    otc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (take),
      .clear_i   (s_axis_tlast),
      .digit_i   (d_in),
      .valid_i   (v_in),
      .pat_nib_i (pattern_q[pidx]),
      .active_i  (active),
      .digit_o   (win_digit[k]),
      .valid_o   (win_valid[k]),
      .hit_o     (cell_hit[k])
    );
  end

  assign ctl.take = take;
  assign ctl.last = s_axis_tlast;
  assign ctl.hit  = (&cell_hit) && (len_eff != '0);

  otc_tally u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .len_i       (len_eff),
    .res_ready_i (m_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(res);

  a_found_matches_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.found == (res.match_count != '0)))
    else $error("found flag disagrees with occurrence count");

  a_start_with_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((res.last_start != '0) == (res.match_count != '0)))
    else $error("latest start disagrees with occurrence count");

  a_result_follows_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && s_axis_tlast) |=> m_axis_tvalid)
    else $error("no result after final digit transaction");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result is stalled");

endmodule
